FILE: rtl/hfsp_pkg.sv
package hfsp_pkg;

    // Sizes
    localparam int MAX_FRAME_BYTES_DEF = 16;
    localparam int BYTE_W              = 8;
    localparam int KIND_W              = 2;
    localparam int CFG_LEN_W           = 5;
    localparam int CFG_IDX_W           = 3;
    localparam int MAX_RES             = 4;
    localparam int NRES_W              = 3;
    localparam int MIN_FRAME_LEN       = 3;
    localparam int PAYLOAD_W           = 4 * BYTE_W + 3;
    localparam int OUT_TDATA_W         = ((PAYLOAD_W + 7) / 8) * 8;

    // Frame bytes
    localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'h55;
    localparam logic [BYTE_W-1:0] TYPE_PAGE    = 8'hAA;
    localparam logic [BYTE_W-1:0] TYPE_SETTING = 8'hBB;
    localparam logic [BYTE_W-1:0] TYPE_DATA    = 8'hCC;
    localparam logic [BYTE_W-1:0] TYPE_COMMAND = 8'hDD;
    localparam logic [BYTE_W-1:0] TAIL_PAGE    = 8'h0A;
    localparam logic [BYTE_W-1:0] TAIL_SETTING = 8'h0B;
    localparam logic [BYTE_W-1:0] TAIL_DATA    = 8'h0C;
    localparam logic [BYTE_W-1:0] TAIL_COMMAND = 8'h0D;

    // Page checks
    localparam logic [BYTE_W-1:0] PAGE_NIBBLE_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] SETTING_PAGE_LOW = 8'h01;
    localparam logic [BYTE_W-1:0] PAGE_LIVE        = 8'h02;
    localparam logic [BYTE_W-1:0] PAGE_LIVE_ALT    = 8'h03;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_LEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTING_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_LEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_LEN = 3'd3;
    localparam logic [CFG_LEN_W-1:0] PAGE_LEN_RST    = 5'd4;
    localparam logic [CFG_LEN_W-1:0] SETTING_LEN_RST = 5'd6;
    localparam logic [CFG_LEN_W-1:0] DATA_LEN_RST    = 5'd16;
    localparam logic [CFG_LEN_W-1:0] COMMAND_LEN_RST = 5'd6;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAGE,
        KIND_SETTING,
        KIND_DATA,
        KIND_COMMAND
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_B0,
        ST_B1,
        ST_TAIL,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_EMIT,
        ST_FINISH
    } state_t;

    // Window offset to read
    typedef enum logic [2:0] {
        SEL_HEAD,
        SEL_TYPE,
        SEL_TAIL,
        SEL_CMD,
        SEL_LOAD1,
        SEL_LOAD2
    } rd_sel_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] page_id;
        logic [BYTE_W-1:0] cmd_code;
        logic [BYTE_W-1:0] load_one;
        logic [BYTE_W-1:0] load_two;
        logic              accepted;
        logic              flush_tx;
        logic              refresh_data;
    } result_t;

    typedef struct packed {
        logic    take_byte;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    drop_one;
        logic    load_kind;
        logic    load_p2;
        logic    load_p3;
        logic    load_p4;
        logic    commit;
        logic    push;
        logic    push_last;
    } dp_cmd_t;

    typedef struct packed {
        logic count_ge2;
        logic nres_full;
        logic b0_sync;
        logic b1_known;
        logic frame_short;
        logic tail_ok;
        logic staged_valid;
        logic out_free;
    } dp_status_t;

    function automatic logic [BYTE_W-1:0] tail_code(input kind_t k);
        logic [BYTE_W-1:0] t;
        case (k)
            KIND_PAGE:    t = TAIL_PAGE;
            KIND_SETTING: t = TAIL_SETTING;
            KIND_DATA:    t = TAIL_DATA;
            KIND_COMMAND: t = TAIL_COMMAND;
            default:      t = TAIL_PAGE;
        endcase
        return t;
    endfunction

endpackage

FILE: rtl/hfsp_ram.sv
module hfsp_ram
    import hfsp_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = MAX_FRAME_BYTES_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/hfsp_dpath.sv
module hfsp_dpath
    import hfsp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_LEN_W-1:0] cfg_wdata,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 m_tready,
    output result_t              out_result,
    output logic                 out_valid,
    output logic                 out_last
);

    localparam int PTR_W = $clog2(MAX_FRAME_BYTES);
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W;
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CMP_W-1:0] LEN_MIN   = CMP_W'(MIN_FRAME_LEN);
    localparam logic [CMP_W-1:0] LEN_MAX   = CMP_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] OFF_HEAD  = CNT_W'(0);
    localparam logic [CNT_W-1:0] OFF_TYPE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] OFF_CMD   = CNT_W'(2);
    localparam logic [CNT_W-1:0] OFF_LOAD1 = CNT_W'(3);
    localparam logic [CNT_W-1:0] OFF_LOAD2 = CNT_W'(4);

    // Circular add with one conditional subtract
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(MAX_FRAME_BYTES)) begin
            sum = sum - SUM_W'(MAX_FRAME_BYTES);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Bound a configured length to the legal range
    function automatic logic [CNT_W-1:0] clamp_len(input logic [CFG_LEN_W-1:0] raw);
        logic [CMP_W-1:0] v;
        v = CMP_W'(raw);
        if (v < LEN_MIN) begin
            v = LEN_MIN;
        end else if (v > LEN_MAX) begin
            v = LEN_MAX;
        end
        return v[CNT_W-1:0];
    endfunction

    logic [CFG_LEN_W-1:0] len_cfg_reg [4];
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NRES_W-1:0]    nres_reg;
    logic [BYTE_W-1:0]    page_reg;
    kind_t                kind_reg;
    logic [CNT_W-1:0]     len_reg;
    logic [BYTE_W-1:0]    p2_reg, p3_reg, p4_reg;
    result_t              staged_reg;
    logic                 staged_valid_reg;
    result_t              out_reg;
    logic                 out_valid_reg;
    logic                 out_last_reg;

    kind_t                kind_dec;
    logic                 kind_known;
    logic [CNT_W-1:0]     len_dec;
    logic [CNT_W-1:0]     rd_off;
    logic [CNT_W-1:0]     drop_len;
    logic [PTR_W-1:0]     rd_addr;
    logic [PTR_W-1:0]     wr_addr;
    logic                 wr_en;
    logic [BYTE_W-1:0]    rd_data;
    result_t              res_new;

    // Pending byte window
    hfsp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Decode the type byte straight off the read port
    always_comb begin
        kind_known = 1'b1;
        case (rd_data)
            TYPE_PAGE:    kind_dec = KIND_PAGE;
            TYPE_SETTING: kind_dec = KIND_SETTING;
            TYPE_DATA:    kind_dec = KIND_DATA;
            TYPE_COMMAND: kind_dec = KIND_COMMAND;
            default: begin
                kind_dec   = KIND_PAGE;
                kind_known = 1'b0;
            end
        endcase
        len_dec = clamp_len(len_cfg_reg[kind_dec]);
    end

    // Select the window offset to read
    always_comb begin
        case (cmd.rd_sel)
            SEL_HEAD:  rd_off = OFF_HEAD;
            SEL_TYPE:  rd_off = OFF_TYPE;
            SEL_TAIL:  rd_off = len_dec - OFF_TYPE;
            SEL_CMD:   rd_off = OFF_CMD;
            SEL_LOAD1: rd_off = OFF_LOAD1;
            SEL_LOAD2: rd_off = OFF_LOAD2;
            default:   rd_off = OFF_HEAD;
        endcase
    end

    assign rd_addr = wrap_add(head_reg, rd_off);
    assign wr_addr = wrap_add(head_reg, count_reg);
    assign wr_en   = cmd.take_byte && (count_reg < CNT_FULL);

    // Append a byte or consume from the head
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        drop_len   = cmd.commit ? len_reg : OFF_TYPE;
        if (wr_en) begin
            count_next = count_reg + OFF_TYPE;
        end else if (cmd.drop_one || cmd.commit) begin
            head_next  = wrap_add(head_reg, drop_len);
            count_next = count_reg - drop_len;
        end
    end

    // Build the result of the frame just checked
    always_comb begin
        res_new         = '0;
        res_new.kind    = kind_reg;
        res_new.page_id = page_reg;
        case (kind_reg)
            KIND_PAGE: begin
                res_new.page_id      = p2_reg;
                res_new.flush_tx     = (page_reg == PAGE_LIVE) && (p2_reg != PAGE_LIVE);
                res_new.refresh_data = (page_reg != PAGE_LIVE) && (p2_reg == PAGE_LIVE);
            end
            KIND_SETTING: begin
                res_new.cmd_code = p2_reg;
                res_new.load_one = p3_reg;
                res_new.load_two = p4_reg;
                res_new.accepted = (page_reg & PAGE_NIBBLE_MASK) == SETTING_PAGE_LOW;
            end
            KIND_COMMAND: begin
                res_new.cmd_code = p2_reg;
                res_new.load_one = p3_reg;
                res_new.load_two = p4_reg;
                res_new.accepted = (page_reg == PAGE_LIVE) || (page_reg == PAGE_LIVE_ALT);
            end
            default: begin
                res_new.cmd_code = '0;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg[0]   <= PAGE_LEN_RST;
            len_cfg_reg[1]   <= SETTING_LEN_RST;
            len_cfg_reg[2]   <= DATA_LEN_RST;
            len_cfg_reg[3]   <= COMMAND_LEN_RST;
            head_reg         <= '0;
            count_reg        <= '0;
            nres_reg         <= '0;
            page_reg         <= '0;
            staged_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PAGE_LEN:    len_cfg_reg[0] <= cfg_wdata;
                    REG_SETTING_LEN: len_cfg_reg[1] <= cfg_wdata;
                    REG_DATA_LEN:    len_cfg_reg[2] <= cfg_wdata;
                    REG_COMMAND_LEN: len_cfg_reg[3] <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.take_byte) begin
                nres_reg <= '0;
            end else if (cmd.commit) begin
                nres_reg <= nres_reg + NRES_W'(1);
            end
            if (cmd.commit && (kind_reg == KIND_PAGE)) begin
                page_reg <= p2_reg;
            end
            if (cmd.commit) begin
                staged_valid_reg <= 1'b1;
            end else if (cmd.push) begin
                staged_valid_reg <= 1'b0;
            end
            if (cmd.push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_kind) begin
            kind_reg <= kind_dec;
            len_reg  <= len_dec;
        end
        if (cmd.load_p2) begin
            p2_reg <= (OFF_CMD < len_reg) ? rd_data : '0;
        end
        if (cmd.load_p3) begin
            p3_reg <= (OFF_LOAD1 < len_reg) ? rd_data : '0;
        end
        if (cmd.load_p4) begin
            p4_reg <= (OFF_LOAD2 < len_reg) ? rd_data : '0;
        end
        if (cmd.commit) begin
            staged_reg <= res_new;
        end
        if (cmd.push) begin
            out_reg      <= staged_reg;
            out_last_reg <= cmd.push_last;
        end
    end

    // Status to the controller
    assign status.count_ge2    = count_reg >= OFF_CMD;
    assign status.nres_full    = nres_reg == NRES_W'(MAX_RES);
    assign status.b0_sync      = rd_data == SYNC_BYTE;
    assign status.b1_known     = kind_known;
    assign status.frame_short  = count_reg < len_dec;
    assign status.tail_ok      = rd_data == tail_code(kind_reg);
    assign status.staged_valid = staged_valid_reg;
    assign status.out_free     = !out_valid_reg || m_tready;

    assign out_result = out_reg;
    assign out_valid  = out_valid_reg;
    assign out_last   = out_last_reg;

endmodule

FILE: rtl/hfsp_ctrl.sv
module hfsp_ctrl
    import hfsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_byte = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!status.count_ge2 || status.nres_full) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = SEL_HEAD;
                    state_next = ST_B0;
                end
            end
            ST_B0: begin
                if (!status.b0_sync) begin
                    cmd.drop_one = 1'b1;
                    state_next   = ST_CHECK;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = SEL_TYPE;
                    state_next = ST_B1;
                end
            end
            ST_B1: begin
                cmd.load_kind = 1'b1;
                if (!status.b1_known) begin
                    cmd.drop_one = 1'b1;
                    state_next   = ST_CHECK;
                end else if (status.frame_short) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = SEL_TAIL;
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (!status.tail_ok) begin
                    cmd.drop_one = 1'b1;
                    state_next   = ST_CHECK;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = SEL_CMD;
                    state_next = ST_P2;
                end
            end
            ST_P2: begin
                cmd.load_p2 = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = SEL_LOAD1;
                state_next  = ST_P3;
            end
            ST_P3: begin
                cmd.load_p3 = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = SEL_LOAD2;
                state_next  = ST_P4;
            end
            ST_P4: begin
                cmd.load_p4 = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                // Hand the older frame on, not last, before staging this one
                if (!status.staged_valid || status.out_free) begin
                    cmd.commit = 1'b1;
                    cmd.push   = status.staged_valid;
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (!status.staged_valid) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/hmi_frame_sync_parser_top.sv
// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   s_tdata: rx_byte
// m_        out        m_tvalid / m_tready   m_tdata, m_tuser: frame_kind, m_tlast
// cfg_      in         cfg_we                cfg_index, cfg_wdata (frame lengths)
//
// After a byte is taken, the window is scanned through the single read port of the
// window RAM: a scan step either drops one byte that does not start a frame, emits a
// frame, held by any output stall, or ends the scan, also when it stops on a frame
// that is not complete yet; the end waits out any output stall for the last result.
// Reset is synchronous, active low; the window contents are not cleared.
// A full output register holds the scan when a second result is ready.
module hmi_frame_sync_parser_top
    import hfsp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] page_id, [15:8] cmd_code, [23:16] load_one, [31:24] load_two,
    // [32] accepted, [33] flush_tx, [34] refresh_data, [39:35] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]      m_tuser,   // [1:0] frame_kind
    output logic                   m_tlast,   // last_of_run
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_LEN_W-1:0]   cfg_wdata
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    result_t    out_result;

    hfsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    hfsp_dpath #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rx_byte    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cmd        (dp_cmd),
        .status     (dp_status),
        .m_tready   (m_tready),
        .out_result (out_result),
        .out_valid  (m_tvalid),
        .out_last   (m_tlast)
    );

    // Pack the result transaction
    assign m_tdata = {(OUT_TDATA_W - PAYLOAD_W)'(0),
                      out_result.refresh_data,
                      out_result.flush_tx,
                      out_result.accepted,
                      out_result.load_two,
                      out_result.load_one,
                      out_result.cmd_code,
                      out_result.page_id};
    assign m_tuser = out_result.kind;

    // No staged result survives into idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !dp_status.staged_valid)
        else $error("staged result left behind at scan end");

    // One byte at a time: ready drops after each input transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken during a scan");

    // Never overwrite a result the sink has not taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.push |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while stalled");

endmodule
